// ===== design/bmorph_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 binary morphology block.
// No dependencies; used by the result queue and the top level.

package bmorph_pkg;

    // Default largest frame width (row store depth)
    localparam int BMORPH_MAX_WIDTH = 1024;

    // APB address width: three 32-bit registers at byte offsets 0, 4, 8
    localparam int BMORPH_ADDR_W = 4;

    // Register indexes (paddr[3:2]); byte address is four times the index
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // op_mode codes
    localparam logic [1:0] MODE_ERODE    = 2'd0;
    localparam logic [1:0] MODE_DILATE   = 2'd1;
    localparam logic [1:0] MODE_BOUNDARY = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Most results one pixel can cause
    localparam int BMORPH_MAX_RES = 4;
    localparam int BMORPH_RES_CW  = 3;

    // Result queue geometry (power of two depth)
    localparam int BMORPH_Q_DEPTH = 8;
    localparam int BMORPH_Q_AW    = 3;
    localparam int BMORPH_Q_CW    = 4;

    typedef struct packed {
        logic        pixel_out;
        logic [9:0]  out_col;
        logic [11:0] out_row;
        logic        frame_end;
    } t_result;

    // Words handed from the window logic to the queue in the same cycle
    typedef struct packed {
        logic [BMORPH_RES_CW-1:0]         count;
        t_result [BMORPH_MAX_RES-1:0]     word;
    } t_push;

endpackage

// ===== design/bmorph_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixels in and morphology results out.
// Depends on nothing; the top level and the result queue use them.

interface bmorph_pix_if;
    logic valid;
    logic ready;
    logic pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bmorph_res_if;
    logic        valid;
    logic        ready;
    logic        pixel_out;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic        frame_end;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input frame_end, output ready);
endinterface

// ===== design/binary_morph_3x3_top.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 binary erode / dilate / boundary block.
// Depends on bmorph_pkg, bmorph_if (stream interfaces) and bmorph_outq.

// Pixels arrive in raster order, one word per pixel, and each result word
// carries the operated center pixel with its column and row; pixels outside
// the frame count as background. The result for center (r-1, c-1) is formed
// when pixel (r, c) arrives, so row 0 gives no results, the last column adds
// the right-edge result, and the last row adds its own results as it streams
// in; the final pixel gives four words, the last flagged with frame_end. A
// pixel is taken every clock on all rows but the last unless the output
// stalls; its words enter the result queue at the accepting edge and, if it
// was empty, appear at the result port in the cycle after. On the last row
// each pixel but the first causes two results while the port drains at most
// one per clock, so the queue holds input back there, and the final pixel
// waits for four free slots in the eight-word queue. A pixel is accepted
// whenever the queue has room for its results, independent of the output stall.
// The row store holds no reset state and needs no clearing pass: row 0 and
// row 1 mask what they read from it. Registers (APB, 32-bit, pready always
// high): 0x0 frame_width, 0x4 frame_height, 0x8 op_mode (0 erode, 1 dilate,
// 2 boundary mark, 3 gives zero). Out-of-range sizes are clamped to
// 2..MAX_WIDTH and 2..4096; write them only while the block is idle.

module binary_morph_3x3_top #(
    parameter int MAX_WIDTH = bmorph_pkg::BMORPH_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bmorph_pix_if.sink                           i_pix,
    bmorph_res_if.source                         o_res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bmorph_pkg::BMORPH_ADDR_W-1:0] paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RES_CW = bmorph_pkg::BMORPH_RES_CW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [1:0]  r_mode;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
            r_mode   <= bmorph_pkg::MODE_ERODE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bmorph_pkg::REG_WIDTH:  r_width  <= pwdata[10:0];
                bmorph_pkg::REG_HEIGHT: r_height <= pwdata[12:0];
                bmorph_pkg::REG_MODE:   r_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bmorph_pkg::REG_WIDTH:  prdata = {21'd0, r_width};
            bmorph_pkg::REG_HEIGHT: prdata = {19'd0, r_height};
            bmorph_pkg::REG_MODE:   prdata = {30'd0, r_mode};
            default:                prdata = '0;
        endcase
    end

    // Clamp the frame size; keep the index of the last column and last row
    logic [COL_W-1:0] last_col;
    logic [11:0]      last_row_idx;

    always_comb begin
        if (r_width < 11'd2) begin
            last_col = COL_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(32'(r_width) - 32'd1);
        end
        if (r_height < 13'd2) begin
            last_row_idx = 12'd1;
        end else if (r_height > 13'd4096) begin
            last_row_idx = 12'd4095;
        end else begin
            last_row_idx = 12'(r_height - 13'd1);
        end
    end

    // ------------------------------------------------------------------
    // Raster position, window and row store
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [11:0]      r_row;
    logic [5:0]       r_win;     // [2:0] column c-1, [5:3] column c-2
    logic [1:0]       r_rd;      // row store entry for r_col, read ahead
    logic [1:0]       r_store [MAX_WIDTH];

    logic [COL_W-1:0] n_col;
    logic [11:0]      n_row;
    logic [5:0]       n_win;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] col_m1;
    logic             acc;
    logic             row_end;
    logic             last_row;
    logic             has_up;
    logic             has_left;
    logic [1:0]       prev;
    logic [2:0]       cur;
    logic [5:0]       win;
    logic [2:0]       left;
    logic [2:0]       mid;
    logic             sel_a, sel_b, sel_c, sel_d;
    logic [RES_CW-1:0] need;
    logic [bmorph_pkg::BMORPH_Q_CW-1:0] q_free;
    bmorph_pkg::t_push push;

    function automatic logic morph_eval(input logic [1:0] mode, input logic [2:0] l,
                                        input logic [2:0] m, input logic [2:0] rt);
        logic all_on;
        logic any_on;
        logic res;
        all_on = (l == 3'b111) && (m == 3'b111) && (rt == 3'b111);
        any_on = |(l | m | rt);
        case (mode)
            bmorph_pkg::MODE_ERODE:    res = all_on;
            bmorph_pkg::MODE_DILATE:   res = any_on;
            bmorph_pkg::MODE_BOUNDARY: res = m[1] && !all_on;
            default:                   res = 1'b0;
        endcase
        return res;
    endfunction

    assign row_end  = (r_col >= last_col);
    assign last_row = (r_row >= last_row_idx);
    assign has_up   = (r_row != 12'd0);
    assign has_left = (r_col != '0);
    assign col_m1   = r_col - COL_W'(1);

    // Mask store contents that belong to rows above the frame
    always_comb begin
        if (r_row == 12'd0) begin
            prev = 2'b00;
        end else if (r_row == 12'd1) begin
            prev = {1'b0, r_rd[0]};
        end else begin
            prev = r_rd;
        end
    end

    assign cur  = {prev, i_pix.pixel_in};
    assign win  = has_left ? r_win : 6'd0;
    assign left = win[5:3];
    assign mid  = win[2:0];

    assign sel_a = has_up && has_left;
    assign sel_b = has_up && row_end;
    assign sel_c = last_row && has_left;
    assign sel_d = last_row && row_end;
    assign need  = RES_CW'(sel_a) + RES_CW'(sel_b) + RES_CW'(sel_c) + RES_CW'(sel_d);

    // Take a pixel only when the queue can hold every result it causes
    assign i_pix.ready = (bmorph_pkg::BMORPH_Q_CW'(need) <= q_free);
    assign acc         = i_pix.valid && i_pix.ready;

    // Pack the selected results in schedule order
    always_comb begin
        logic [1:0] idx;
        idx        = 2'd0;
        push       = '0;
        push.count = acc ? need : '0;
        if (sel_a) begin
            push.word[idx] = '{pixel_out: morph_eval(r_mode, left, mid, cur),
                               out_col: 10'(col_m1), out_row: r_row - 12'd1,
                               frame_end: 1'b0};
            idx = idx + 2'd1;
        end
        if (sel_b) begin
            push.word[idx] = '{pixel_out: morph_eval(r_mode, mid, cur, 3'b000),
                               out_col: 10'(r_col), out_row: r_row - 12'd1,
                               frame_end: 1'b0};
            idx = idx + 2'd1;
        end
        if (sel_c) begin
            push.word[idx] = '{pixel_out: morph_eval(r_mode, {left[1:0], 1'b0},
                                                     {mid[1:0], 1'b0}, {cur[1:0], 1'b0}),
                               out_col: 10'(col_m1), out_row: r_row, frame_end: 1'b0};
            idx = idx + 2'd1;
        end
        if (sel_d) begin
            push.word[idx] = '{pixel_out: morph_eval(r_mode, {mid[1:0], 1'b0},
                                                     {cur[1:0], 1'b0}, 3'b000),
                               out_col: 10'(r_col), out_row: r_row, frame_end: 1'b1};
        end
    end

    // Advance the raster position; wrap the frame after the last row
    always_comb begin
        n_win = {mid, cur};
        if (row_end) begin
            n_col = '0;
            n_row = last_row ? 12'd0 : r_row + 12'd1;
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_win <= n_win;
        end
    end

    // Prefetch the entry for the next column so it is ready with the pixel
    assign rd_addr = acc ? n_col : r_col;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_store[r_col] <= cur[1:0];
        end
        r_rd <= r_store[rd_addr];
    end

    bmorph_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (q_free),
        .o_res   (o_res)
    );

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && row_end |=> r_col == '0)
        else $error("column did not wrap at row end");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && row_end && last_row |=> r_row == 12'd0)
        else $error("row did not wrap at frame end");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !row_end |=> r_col == $past(r_col) + COL_W'(1))
        else $error("column did not advance by one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_col) && $stable(r_row))
        else $error("raster position moved without a pixel");

endmodule

// ===== design/bmorph_outq.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to four result words per cycle, drains one per cycle while o_res.ready is high.
// Depends on bmorph_pkg and bmorph_res_if.

module bmorph_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmorph_pkg::t_push             i_push,
    output logic [bmorph_pkg::BMORPH_Q_CW-1:0] o_free,
    bmorph_res_if.source                  o_res
);

    localparam int AW = bmorph_pkg::BMORPH_Q_AW;
    localparam int CW = bmorph_pkg::BMORPH_Q_CW;

    bmorph_pkg::t_result r_q [bmorph_pkg::BMORPH_Q_DEPTH];
    logic [AW-1:0]       r_rd;
    logic [AW-1:0]       r_wr;
    logic [CW-1:0]       r_count;
    logic                pop;

    assign pop    = o_res.valid && o_res.ready;
    assign o_free = CW'(bmorph_pkg::BMORPH_Q_DEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= r_rd + AW'(pop);
            r_wr    <= r_wr + AW'(i_push.count);
            r_count <= r_count + CW'(i_push.count) - CW'(pop);
        end
    end

    // Slots are independent; only the first count words land
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bmorph_pkg::BMORPH_MAX_RES; k++) begin
            if (bmorph_pkg::BMORPH_RES_CW'(k) < i_push.count) begin
                r_q[r_wr + AW'(k)] <= i_push.word[k];
            end
        end
    end

    assign o_res.valid     = (r_count != '0);
    assign o_res.pixel_out = r_q[r_rd].pixel_out;
    assign o_res.out_col   = r_q[r_rd].out_col;
    assign o_res.out_row   = r_q[r_rd].out_row;
    assign o_res.frame_end = r_q[r_rd].frame_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(i_push.count) <= o_free)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(bmorph_pkg::BMORPH_Q_DEPTH))
        else $error("result queue count out of range");

endmodule
